FILE: design/kmqm_pkg.sv
// Package for the keyed multi-queue manager: action, status and back-end state codes,
// the command record passed from front to back. No dependencies.
package kmqm_pkg;
	typedef enum logic [1:0] {
		ACT_CREATE = 2'd0,
		ACT_ADD    = 2'd1,
		ACT_GET    = 2'd2,
		ACT_DELETE = 2'd3
	} action_t;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
	localparam logic [2:0] ST_EMPTY      = 3'd2;
	localparam logic [2:0] ST_QUEUE_FULL = 3'd3;
	localparam logic [2:0] ST_TABLE_FULL = 3'd4;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] queue_id;
		logic [31:0] message_in;
	} cmd_t;
endpackage

FILE: design/kmqm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module kmqm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

FILE: design/kmqm_front.sv
// Front end: takes command transactions and holds them in a two-entry queue
// for the back end. Depends on kmqm_pkg.
module kmqm_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    action,
	input  logic [31:0]   queue_id,
	input  logic [31:0]   message_in,
	output logic          busy,
	output logic          cmd_valid,
	output kmqm_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import kmqm_pkg::*;

	cmd_t       buf_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign busy      = cnt_q[1];
	assign push      = start && !busy;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= '{action_t'(action), queue_id, message_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (cmd_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end
endmodule

FILE: design/kmqm_back.sv
// Back end: queue table, per-slot FIFO pointers and the handle store.
// Depends on kmqm_pkg and kmqm_ram.
module kmqm_back #(
	parameter int MAX_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  kmqm_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           done,
	output logic [2:0]     status,
	output logic [31:0]    message_out,
	output logic [3:0]     queues_in_use,
	output logic [4:0]     messages_left
);
	import kmqm_pkg::*;

	localparam int SW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
	localparam int CW = $clog2(MAX_QUEUES + 1);
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(MAX_QUEUES * QUEUE_DEPTH);

	logic [31:0]   ids_q  [MAX_QUEUES];
	logic [SW-1:0] slot_q [MAX_QUEUES];
	logic [CW-1:0] count_q;
	logic [MAX_QUEUES-1:0] busy_q;
	logic [PW-1:0] head_q [MAX_QUEUES];
	logic [FW-1:0] fill_q [MAX_QUEUES];

	back_state_t state_q, state_d;

	// lookup
	logic          found;
	logic [SW-1:0] pos;
	logic          free_ok;
	logic [SW-1:0] free_s;
	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int i = MAX_QUEUES - 1; i >= 0; i--) begin
			if (CW'(i) < count_q && ids_q[i] == cmd.queue_id) begin
				found = 1'b1;
				pos   = SW'(i);
			end
		end
		free_ok = 1'b0;
		free_s  = '0;
		for (int i = MAX_QUEUES - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_ok = 1'b1;
				free_s  = SW'(i);
			end
		end
	end

	logic [SW-1:0] s;
	logic [FW-1:0] fill;
	logic [PW-1:0] head;
	logic [FW:0]   wsum;
	logic [PW-1:0] wptr;
	logic [PW-1:0] head_nxt;
	assign s    = slot_q[pos];
	assign fill = fill_q[s];
	assign head = head_q[s];
	// head + fill stays below twice the depth, so one subtract wraps it
	assign wsum = (FW+1)'(head) + (FW+1)'(fill);
	assign wptr = PW'((wsum >= (FW+1)'(QUEUE_DEPTH)) ? wsum - (FW+1)'(QUEUE_DEPTH) : wsum);
	assign head_nxt = (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;

	logic          go;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_rdata;
	logic [AW-1:0] base;
	assign go   = state_q == BK_IDLE && cmd_valid;
	assign base = AW'(s) * AW'(QUEUE_DEPTH);
	assign ram_we    = go && cmd.action == ACT_ADD && found &&
		fill < FW'(QUEUE_DEPTH);
	assign ram_waddr = base + AW'(wptr);
	assign ram_raddr = base + AW'(head);

	kmqm_ram #(.WIDTH(32), .DEPTH(MAX_QUEUES * QUEUE_DEPTH)) u_store (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(cmd.message_in),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// get with data: the registered read lands in the done cycle
	logic pop_rd;
	assign pop_rd = go && cmd.action == ACT_GET && found && fill != '0;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (go) state_d = BK_DONE;
			BK_READ: state_d = BK_DONE;
			BK_DONE: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = go;
		done    = state_q == BK_DONE;
	end

	logic          rd_pend_q;
	logic [2:0]    st_q;
	logic [FW-1:0] left_q;

	assign status        = st_q;
	assign message_out   = rd_pend_q ? ram_rdata : 32'd0;
	assign queues_in_use = 4'(count_q);
	assign messages_left = 5'(left_q);

	always_ff @(posedge clk) begin
		if (go) begin
			if (cmd.action == ACT_CREATE && count_q < CW'(MAX_QUEUES) && free_ok) begin
				ids_q[count_q[SW-1:0]]  <= cmd.queue_id;
				slot_q[count_q[SW-1:0]] <= free_s;
			end
			if (cmd.action == ACT_DELETE && found) begin
				for (int i = 0; i < MAX_QUEUES - 1; i++) begin
					if (SW'(i) >= pos) begin
						ids_q[i]  <= ids_q[i+1];
						slot_q[i] <= slot_q[i+1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			count_q   <= '0;
			busy_q    <= '0;
			rd_pend_q <= 1'b0;
			st_q      <= ST_OK;
			left_q    <= '0;
			for (int i = 0; i < MAX_QUEUES; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (go) begin
				rd_pend_q <= pop_rd;
				st_q      <= ST_OK;
				left_q    <= '0;
				unique case (cmd.action)
					ACT_CREATE: begin
						if (count_q >= CW'(MAX_QUEUES) || !free_ok) begin
							st_q <= ST_TABLE_FULL;
						end else begin
							busy_q[free_s] <= 1'b1;
							head_q[free_s] <= '0;
							fill_q[free_s] <= '0;
							count_q        <= count_q + 1'b1;
						end
					end
					ACT_ADD: begin
						if (!found) st_q <= ST_NOT_FOUND;
						else if (fill >= FW'(QUEUE_DEPTH)) begin
							st_q   <= ST_QUEUE_FULL;
							left_q <= fill;
						end else begin
							fill_q[s] <= fill + 1'b1;
							left_q    <= fill + 1'b1;
						end
					end
					ACT_GET: begin
						if (!found) st_q <= ST_NOT_FOUND;
						else if (fill == '0) st_q <= ST_EMPTY;
						else begin
							head_q[s] <= head_nxt;
							fill_q[s] <= fill - 1'b1;
							left_q    <= fill - 1'b1;
						end
					end
					ACT_DELETE: begin
						if (!found) st_q <= ST_NOT_FOUND;
						else begin
							busy_q[s] <= 1'b0;
							head_q[s] <= '0;
							fill_q[s] <= '0;
							count_q   <= count_q - 1'b1;
						end
					end
					default: st_q <= ST_OK;
				endcase
			end
		end
	end
endmodule

FILE: design/keyed_multi_queue_manager.sv
// Keyed multi-queue manager top level: front command queue and back engine.
// Depends on kmqm_pkg, kmqm_front, kmqm_back.
// Flow: an accepted start waits in the front command queue until the back
//   engine takes it in BK_IDLE; done follows from BK_DONE for every action.
// Results are registered; the back engine takes no new command in BK_DONE.
// Reset: arst_n clears the table count, slot flags and FIFO pointers.
module keyed_multi_queue_manager #(
	parameter int MAX_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [31:0] queue_id,
	input  logic [31:0] message_in,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] message_out,
	output logic [3:0]  queues_in_use,
	output logic [4:0]  messages_left
);
	import kmqm_pkg::*;

	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	kmqm_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .action(action),
		.queue_id(queue_id), .message_in(message_in), .busy(busy),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	kmqm_back #(.MAX_QUEUES(MAX_QUEUES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_pop(cmd_pop), .done(done), .status(status),
		.message_out(message_out), .queues_in_use(queues_in_use),
		.messages_left(messages_left)
	);

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid) else $error("pop from empty command queue");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= ST_TABLE_FULL) else $error("bad status");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		queues_in_use <= 4'(MAX_QUEUES)) else $error("queue count overflow");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");
endmodule

FILE: sim/tb_keyed_multi_queue_manager.sv
// Testbench for keyed_multi_queue_manager: drives create/add/get/delete
// transactions and checks every done strobe against a behavioural predictor.
// Depends on kmqm_pkg and the design top level.
`timescale 1ns / 1ps

module tb_keyed_multi_queue_manager;
	import kmqm_pkg::*;

	localparam int NQ = 8;
	localparam int DEPTH = 16;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic [2:0]  status;
		logic [31:0] message_out;
		logic [3:0]  queues_in_use;
		logic [4:0]  messages_left;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  action = '0;
	logic [31:0] queue_id = '0;
	logic [31:0] message_in = '0;
	logic        done;
	logic [2:0]  status;
	logic [31:0] message_out;
	logic [3:0]  queues_in_use;
	logic [4:0]  messages_left;

	// predictor state
	logic [31:0] q_ids [NQ];
	int          q_slot [NQ];
	int          q_count;
	bit          slot_used [NQ];
	logic [31:0] slot_msgs [NQ][$];

	reply_t replies_due [$];
	int     errors = 0;
	int     sent = 0;
	int     checked = 0;
	int     idle_cycles = 0;
	int     watchdog_hit = 0;

	keyed_multi_queue_manager u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .queue_id(queue_id), .message_in(message_in),
		.done(done), .status(status), .message_out(message_out),
		.queues_in_use(queues_in_use), .messages_left(messages_left)
	);

	always #5 clk = ~clk;

	function automatic int lookup_queue(logic [31:0] id);
		for (int i = 0; i < q_count; i++)
			if (q_ids[i] == id) return i;
		return -1;
	endfunction

	function automatic reply_t apply_action(action_t act, logic [31:0] id, logic [31:0] msg);
		reply_t r;
		int pos;
		int s;
		r.status = ST_OK;
		r.message_out = '0;
		r.messages_left = '0;
		if (act == ACT_CREATE) begin
			s = -1;
			for (int i = NQ - 1; i >= 0; i--)
				if (!slot_used[i]) s = i;
			if (q_count >= NQ || s < 0) begin
				r.status = ST_TABLE_FULL;
			end else begin
				slot_used[s] = 1'b1;
				slot_msgs[s].delete();
				q_ids[q_count] = id;
				q_slot[q_count] = s;
				q_count++;
			end
		end else begin
			pos = lookup_queue(id);
			if (pos < 0) begin
				r.status = ST_NOT_FOUND;
			end else begin
				s = q_slot[pos];
				case (act)
					ACT_ADD: begin
						if (slot_msgs[s].size() >= DEPTH) r.status = ST_QUEUE_FULL;
						else slot_msgs[s].push_back(msg);
						r.messages_left = 5'(slot_msgs[s].size());
					end
					ACT_GET: begin
						if (slot_msgs[s].size() == 0) r.status = ST_EMPTY;
						else r.message_out = slot_msgs[s].pop_front();
						r.messages_left = 5'(slot_msgs[s].size());
					end
					default: begin
						slot_used[s] = 1'b0;
						slot_msgs[s].delete();
						for (int i = pos; i + 1 < q_count; i++) begin
							q_ids[i] = q_ids[i + 1];
							q_slot[i] = q_slot[i + 1];
						end
						q_count--;
					end
				endcase
			end
		end
		r.queues_in_use = 4'(q_count);
		return r;
	endfunction

	// one transaction, with a random gap first
	task automatic send_action(action_t act, logic [31:0] id, logic [31:0] msg);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		queue_id <= id;
		message_in <= msg;
		@(posedge clk);
		while (busy) @(posedge clk);
		replies_due.push_back(apply_action(act, id, msg));
		sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		reply_t e;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected result status=%0d msg=%h", $time, status, message_out);
				errors++;
			end else begin
				e = replies_due.pop_front();
				checked++;
				if (status !== e.status || message_out !== e.message_out
						|| queues_in_use !== e.queues_in_use
						|| messages_left !== e.messages_left) begin
					$display("%0t: mismatch expected st=%0d msg=%h q=%0d left=%0d actual st=%0d msg=%h q=%0d left=%0d",
						$time, e.status, e.message_out, e.queues_in_use, e.messages_left,
						status, message_out, queues_in_use, messages_left);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted transaction or done strobe
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT && !watchdog_hit) begin
			watchdog_hit = 1;
			$display("FAIL keyed_multi_queue_manager");
			$finish;
		end
	end

	function automatic logic [31:0] pick_id();
		if (q_count > 0 && $urandom_range(0, 9) < 8)
			return q_ids[$urandom_range(0, q_count - 1)];
		return $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 5);
	endfunction

	task automatic test_table_limits();
		send_action(ACT_GET, 32'h0, 32'h0);
		send_action(ACT_ADD, 32'hFFFF_FFFF, 32'h1234);
		send_action(ACT_DELETE, 32'h5, 32'h0);
		for (int i = 0; i < NQ; i++) send_action(ACT_CREATE, i == 0 ? 32'h0 : 32'hFFFF_FFFF, '0);
		send_action(ACT_CREATE, 32'h7, '0);
		send_action(ACT_DELETE, 32'hFFFF_FFFF, '0);
		send_action(ACT_CREATE, 32'h7, '0);
		wait_drained();
	endtask

	task automatic test_fifo_edges();
		send_action(ACT_GET, 32'h0, '0);
		for (int i = 0; i <= DEPTH; i++)
			send_action(ACT_ADD, 32'h0, i == 0 ? 32'h0 : (i == 1 ? 32'hFFFF_FFFF : $urandom()));
		send_action(ACT_GET, 32'h0, 32'hFFFF_FFFF);
		send_action(ACT_GET, 32'h0, '0);
		// delete a queue still holding handles; table closes the gap
		send_action(ACT_DELETE, 32'h0, '0);
		send_action(ACT_GET, 32'h7, '0);
		wait_drained();
	endtask

	task automatic test_random_mix(int n);
		action_t act;
		int roll;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			if (q_count < 2 && roll < 60) act = ACT_CREATE;
			else if (roll < 12) act = ACT_CREATE;
			else if (roll < 55) act = ACT_ADD;
			else if (roll < 90) act = ACT_GET;
			else act = ACT_DELETE;
			send_action(act, pick_id(), $urandom());
		end
		wait_drained();
	endtask

	initial begin
		q_count = 0;
		for (int i = 0; i < NQ; i++) slot_used[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_limits();
		test_fifo_edges();
		test_random_mix(900);
		$display("Sent %0d transactions, %0d results checked, covering table-full,", sent, checked);
		$display("not-found, empty, queue-full, zero handles and deletes of busy queues.");
		if (errors == 0 && replies_due.size() == 0) begin
			$display("PASS keyed_multi_queue_manager");
		end else begin
			$display("FAIL keyed_multi_queue_manager");
		end
		$finish;
	end
endmodule

FILE: keyed_multi_queue_manager.f
design/kmqm_pkg.sv
design/kmqm_ram.sv
design/kmqm_front.sv
design/kmqm_back.sv
design/keyed_multi_queue_manager.sv
sim/tb_keyed_multi_queue_manager.sv
